>>> rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared types and constants of the vertex normal accumulator
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTICES_DEFAULT = 1024;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 16;
  localparam int SUM_W   = 44;
  localparam int EDGE_W  = 17;
  localparam int CROSS_W = 35;
  localparam int NRM_W   = 16;
  localparam int MAG_W   = 20;
  localparam int LEN_W   = 21;
  localparam int SQ_W    = 42;
  localparam int SQRT_STEPS = 21;
  localparam int QUOT_W  = 16;

  localparam logic [NRM_W-1:0] ONE_Q14 = 16'd16384;
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TRI   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POS_A,
    ST_POS_B,
    ST_POS_C,
    ST_EDGE,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_SUM_RD,
    ST_SUM_CAP,
    ST_SCALE,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_OUT
  } state_e;

endpackage

>>> rtl/vna_if.sv
// ----------------------------------------------------------------------------
// vna_if
// valid/ready channels for items into and results out of the accumulator
// ----------------------------------------------------------------------------
interface vna_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [vna_pkg::IDX_W-1:0] index_a;
  logic [vna_pkg::IDX_W-1:0] index_b;
  logic [vna_pkg::IDX_W-1:0] index_c;
  logic signed [vna_pkg::POS_W-1:0] pos_x;
  logic signed [vna_pkg::POS_W-1:0] pos_y;
  logic signed [vna_pkg::POS_W-1:0] pos_z;

  modport source (output valid, action, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, action, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface vna_out_if;
  logic                      valid;
  logic                      ready;
  logic [vna_pkg::IDX_W-1:0] vertex_index;
  logic signed [vna_pkg::NRM_W-1:0] normal_x;
  logic signed [vna_pkg::NRM_W-1:0] normal_y;
  logic signed [vna_pkg::NRM_W-1:0] normal_z;
  logic                      degenerate;

  modport source (output valid, vertex_index, normal_x, normal_y, normal_z, degenerate,
                  input ready);
  modport sink (input valid, vertex_index, normal_x, normal_y, normal_z, degenerate,
                output ready);
endinterface

>>> rtl/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// area-weighted smooth vertex normals with unit-length Q1.14 read-out
// ----------------------------------------------------------------------------
// The block holds one position and one saturating normal sum per vertex in two
// synchronous RAMs and handles one item at a time. A vertex write goes into the
// RAMs in the cycle it is accepted. A triangle goes through three position reads,
// the edge vectors, the three cross product components on two shared multipliers,
// then a read and a write-back of the sum RAM for each corner in turn. A normal
// read passes through the shift-one-bit-a-cycle scaler, the bit-serial square
// root and a restoring divider shared by the three components. A finished result
// waits in the output register, which is loaded again only once it has been
// taken.
module vertex_normal_accumulator #(
  parameter int VERTICES = vna_pkg::VERTICES_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  vna_in_if.sink    in_i,
  vna_out_if.source out_o
);
  localparam int AW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int PW  = 3 * vna_pkg::POS_W;
  localparam int SW  = 3 * vna_pkg::SUM_W;
  localparam int SUM_W = vna_pkg::SUM_W;
  localparam int POS_W = vna_pkg::POS_W;

  vna_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic       out_valid_q, out_valid_d;
  logic       load_out;

  // latched item
  logic [vna_pkg::IDX_W-1:0] ia_q, ib_q, ic_q;

  // datapath
  logic signed [POS_W-1:0]   pa_q [3];
  logic signed [POS_W-1:0]   pb_q [3];
  logic signed [vna_pkg::EDGE_W-1:0]  e1_q [3];
  logic signed [vna_pkg::EDGE_W-1:0]  e2_q [3];
  logic signed [vna_pkg::CROSS_W-1:0] cross_q [3];
  logic                      neg_q [3];
  logic [SUM_W-1:0]          mag_q [3];
  logic [vna_pkg::SQ_W-1:0]  v_q;
  logic [vna_pkg::SQ_W:0]    root_q;
  logic [vna_pkg::SQ_W-1:0]  bit_q;
  logic [23:0]               rem_q;
  logic [vna_pkg::QUOT_W-1:0] quot_q;
  logic [vna_pkg::NRM_W-1:0] nrm_q [3];
  logic                      degen_q;

  // ram ports
  logic          pos_we, sum_we;
  logic [AW-1:0] pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [PW-1:0] pos_wdata, pos_rdata;
  logic [SW-1:0] sum_wdata, sum_rdata;

  logic accept;
  logic ia_ok, ib_ok, ic_ok, in_a_ok;
  logic [vna_pkg::IDX_W-1:0] corner;

  assign accept  = in_i.valid && in_i.ready;
  assign in_a_ok = int'(in_i.index_a) < VERTICES;
  assign ia_ok   = int'(in_i.index_a) < VERTICES;
  assign ib_ok   = int'(in_i.index_b) < VERTICES;
  assign ic_ok   = int'(in_i.index_c) < VERTICES;

  always_comb begin
    unique case (comp_q)
      2'd0:    corner = ia_q;
      2'd1:    corner = ib_q;
      default: corner = ic_q;
    endcase
  end

  vna_ram #(.WIDTH(PW), .DEPTH(VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.WIDTH(SW), .DEPTH(VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  // cross product, one component a cycle on two multipliers
  logic signed [vna_pkg::EDGE_W-1:0] mul_a1, mul_b1, mul_a2, mul_b2;
  logic signed [2*vna_pkg::EDGE_W-1:0] prod1, prod2;
  logic signed [vna_pkg::CROSS_W-1:0] cross_new;

  always_comb begin
    unique case (comp_q)
      2'd0: begin
        mul_a1 = e1_q[1]; mul_b1 = e2_q[2]; mul_a2 = e1_q[2]; mul_b2 = e2_q[1];
      end
      2'd1: begin
        mul_a1 = e1_q[2]; mul_b1 = e2_q[0]; mul_a2 = e1_q[0]; mul_b2 = e2_q[2];
      end
      default: begin
        mul_a1 = e1_q[0]; mul_b1 = e2_q[1]; mul_a2 = e1_q[1]; mul_b2 = e2_q[0];
      end
    endcase
    prod1     = mul_a1 * mul_b1;
    prod2     = mul_a2 * mul_b2;
    cross_new = vna_pkg::CROSS_W'(prod1) - vna_pkg::CROSS_W'(prod2);
  end

  // saturating corner update
  logic [SW-1:0] sum_upd;
  always_comb begin
    logic signed [SUM_W:0] t;
    sum_upd = '0;
    for (int k = 0; k < 3; k++) begin
      t = (SUM_W+1)'($signed(sum_rdata[k*SUM_W +: SUM_W])) + (SUM_W+1)'(cross_q[k]);
      if (t[SUM_W] != t[SUM_W-1]) begin
        sum_upd[k*SUM_W +: SUM_W] = t[SUM_W] ? vna_pkg::SUM_MIN : vna_pkg::SUM_MAX;
      end else begin
        sum_upd[k*SUM_W +: SUM_W] = t[SUM_W-1:0];
      end
    end
  end

  // largest magnitude for the scaler
  logic [SUM_W-1:0] mag_max;
  always_comb begin
    mag_max = mag_q[0];
    if (mag_q[1] > mag_max) mag_max = mag_q[1];
    if (mag_q[2] > mag_max) mag_max = mag_q[2];
  end

  logic [vna_pkg::MAG_W-1:0] sq_op;
  logic [2*vna_pkg::MAG_W-1:0] sq_prod;
  assign sq_op   = mag_q[comp_q][vna_pkg::MAG_W-1:0];
  assign sq_prod = sq_op * sq_op;

  // square root step
  logic [vna_pkg::SQ_W:0] sqrt_trial;
  assign sqrt_trial = root_q + (vna_pkg::SQ_W+1)'(bit_q);

  // divider: (mag * 2^15 + len) / (2 * len)
  logic [vna_pkg::LEN_W-1:0] len;
  logic [35:0] div_num;
  logic [22:0] div_den;
  logic [24:0] div_shift;
  assign len       = root_q[vna_pkg::LEN_W-1:0];
  assign div_num   = {sq_op, 15'd0} + 36'(len);
  assign div_den   = {1'b0, len, 1'b0};
  assign div_shift = {rem_q, div_num[cnt_q[3:0]]};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    comp_d   = comp_q;
    load_out = 1'b0;
    in_i.ready = (state_q == vna_pkg::ST_IDLE);
    pos_we    = 1'b0;
    pos_waddr = AW'(in_i.index_a);
    pos_wdata = {in_i.pos_z, in_i.pos_y, in_i.pos_x};
    pos_raddr = AW'(ia_q);
    sum_we    = 1'b0;
    sum_waddr = AW'(in_i.index_a);
    sum_wdata = '0;
    sum_raddr = AW'(corner);

    unique case (state_q)
      vna_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (in_i.action == vna_pkg::ACT_WRITE) begin
            pos_we = in_a_ok;
            sum_we = in_a_ok;
          end else if (in_i.action == vna_pkg::ACT_TRI) begin
            if (ia_ok && ib_ok && ic_ok) state_d = vna_pkg::ST_POS_A;
          end else if (in_i.action == vna_pkg::ACT_READ) begin
            comp_d  = 2'd0;
            state_d = in_a_ok ? vna_pkg::ST_SUM_RD : vna_pkg::ST_OUT;
          end else begin
            state_d = vna_pkg::ST_IDLE;
          end
        end
      end
      vna_pkg::ST_POS_A: begin
        pos_raddr = AW'(ia_q);
        state_d   = vna_pkg::ST_POS_B;
      end
      vna_pkg::ST_POS_B: begin
        pos_raddr = AW'(ib_q);
        state_d   = vna_pkg::ST_POS_C;
      end
      vna_pkg::ST_POS_C: begin
        pos_raddr = AW'(ic_q);
        state_d   = vna_pkg::ST_EDGE;
      end
      vna_pkg::ST_EDGE: begin
        comp_d  = 2'd0;
        state_d = vna_pkg::ST_CROSS;
      end
      vna_pkg::ST_CROSS: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          comp_d  = 2'd0;
          state_d = vna_pkg::ST_ACC_RD;
        end
      end
      vna_pkg::ST_ACC_RD: begin
        state_d = vna_pkg::ST_ACC_WR;
      end
      vna_pkg::ST_ACC_WR: begin
        // write back before the next corner is read, so repeats see it
        sum_we    = 1'b1;
        sum_waddr = AW'(corner);
        sum_wdata = sum_upd;
        comp_d    = comp_q + 2'd1;
        state_d   = (comp_q == 2'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_ACC_RD;
      end
      vna_pkg::ST_SUM_RD: begin
        sum_raddr = AW'(ia_q);
        state_d   = vna_pkg::ST_SUM_CAP;
      end
      vna_pkg::ST_SUM_CAP: begin
        state_d = (sum_rdata == '0) ? vna_pkg::ST_OUT : vna_pkg::ST_SCALE;
      end
      vna_pkg::ST_SCALE: begin
        if (mag_max[SUM_W-1:vna_pkg::MAG_W] == '0 && mag_max[vna_pkg::MAG_W-1]) begin
          comp_d  = 2'd0;
          state_d = vna_pkg::ST_SQUARE;
        end
      end
      vna_pkg::ST_SQUARE: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          cnt_d   = '0;
          state_d = vna_pkg::ST_SQRT;
        end
      end
      vna_pkg::ST_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(vna_pkg::SQRT_STEPS - 1)) begin
          comp_d  = 2'd0;
          state_d = vna_pkg::ST_DIV_INIT;
        end
      end
      vna_pkg::ST_DIV_INIT: begin
        cnt_d   = 5'd15;
        state_d = vna_pkg::ST_DIV_STEP;
      end
      vna_pkg::ST_DIV_STEP: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = vna_pkg::ST_DIV_DONE;
      end
      vna_pkg::ST_DIV_DONE: begin
        comp_d  = comp_q + 2'd1;
        state_d = (comp_q == 2'd2) ? vna_pkg::ST_OUT : vna_pkg::ST_DIV_INIT;
      end
      vna_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = vna_pkg::ST_IDLE;
        end
      end
      default: state_d = vna_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vna_pkg::ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      vna_pkg::ST_IDLE: begin
        if (accept) begin
          ia_q     <= in_i.index_a;
          ib_q     <= in_i.index_b;
          ic_q     <= in_i.index_c;
          degen_q  <= 1'b1;
          nrm_q[0] <= '0;
          nrm_q[1] <= '0;
          nrm_q[2] <= vna_pkg::ONE_Q14;
        end
      end
      vna_pkg::ST_POS_B: begin
        for (int k = 0; k < 3; k++) pa_q[k] <= $signed(pos_rdata[k*POS_W +: POS_W]);
      end
      vna_pkg::ST_POS_C: begin
        for (int k = 0; k < 3; k++) pb_q[k] <= $signed(pos_rdata[k*POS_W +: POS_W]);
      end
      vna_pkg::ST_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= vna_pkg::EDGE_W'(pb_q[k]) - vna_pkg::EDGE_W'(pa_q[k]);
          e2_q[k] <= vna_pkg::EDGE_W'($signed(pos_rdata[k*POS_W +: POS_W]))
                     - vna_pkg::EDGE_W'(pa_q[k]);
        end
      end
      vna_pkg::ST_CROSS: begin
        cross_q[comp_q] <= cross_new;
      end
      vna_pkg::ST_SUM_CAP: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= sum_rdata[k*SUM_W + SUM_W - 1];
          mag_q[k] <= sum_rdata[k*SUM_W + SUM_W - 1] ? -sum_rdata[k*SUM_W +: SUM_W]
                                                     : sum_rdata[k*SUM_W +: SUM_W];
        end
        v_q    <= '0;
        root_q <= '0;
        bit_q  <= vna_pkg::SQ_W'(1) << (vna_pkg::SQ_W - 2);
      end
      vna_pkg::ST_SCALE: begin
        // bring the largest magnitude into [2^19, 2^20)
        if (mag_max[SUM_W-1:vna_pkg::MAG_W] != '0) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
        end else if (!mag_max[vna_pkg::MAG_W-1]) begin
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
        end
      end
      vna_pkg::ST_SQUARE: begin
        v_q <= v_q + vna_pkg::SQ_W'(sq_prod);
      end
      vna_pkg::ST_SQRT: begin
        if ((vna_pkg::SQ_W+1)'(v_q) >= sqrt_trial) begin
          v_q    <= v_q - vna_pkg::SQ_W'(sqrt_trial);
          root_q <= (root_q >> 1) + (vna_pkg::SQ_W+1)'(bit_q);
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      vna_pkg::ST_DIV_INIT: begin
        rem_q  <= 24'(div_num[35:16]);
        quot_q <= '0;
      end
      vna_pkg::ST_DIV_STEP: begin
        if (div_shift >= 25'(div_den)) begin
          rem_q  <= 24'(div_shift - 25'(div_den));
          quot_q <= {quot_q[vna_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= div_shift[23:0];
          quot_q <= {quot_q[vna_pkg::QUOT_W-2:0], 1'b0};
        end
      end
      vna_pkg::ST_DIV_DONE: begin
        nrm_q[comp_q] <= neg_q[comp_q] ? -quot_q : quot_q;
        degen_q       <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.vertex_index <= ia_q;
      out_o.normal_x     <= nrm_q[0];
      out_o.normal_y     <= nrm_q[1];
      out_o.normal_z     <= nrm_q[2];
      out_o.degenerate   <= degen_q;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef NO_ASSERTIONS
  a_sqrt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vna_pkg::ST_DIV_INIT |-> root_q >= 43'd524288 && root_q < 43'd2097152)
    else $error("square root out of range");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vna_pkg::ST_SQUARE |-> mag_max[SUM_W-1:vna_pkg::MAG_W] == '0
                                      && mag_max[vna_pkg::MAG_W-1])
    else $error("scaled magnitude out of range");

  a_degen_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.degenerate |-> out_o.normal_x == '0 && out_o.normal_y == '0
                                        && out_o.normal_z == vna_pkg::ONE_Q14)
    else $error("degenerate result is not the default normal");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.degenerate |->
      out_o.normal_x <= 16'sd16384 && out_o.normal_x >= -16'sd16384 &&
      out_o.normal_y <= 16'sd16384 && out_o.normal_y >= -16'sd16384 &&
      out_o.normal_z <= 16'sd16384 && out_o.normal_z >= -16'sd16384)
    else $error("normal component exceeds one");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vna_pkg::ST_OUT && out_valid_q && !out_o.ready |=> state_q == vna_pkg::ST_OUT)
    else $error("result dropped while output stalled");
`endif
endmodule

>>> test/vertex_normal_accumulator_tb.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb
// self-checking bench: vertex writes, triangle accumulation and normal reads
// are checked against a fixed-point predictor of the normal sums, under
// random stalls on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SAT_TRIS    = 2050;
  localparam int  RAND_ITEMS  = 200;
  localparam longint SUM_HI   = 64'sh0000_07FF_FFFF_FFFF;
  localparam longint SUM_LO   = -SUM_HI - 1;

  typedef struct {
    vna_pkg::action_e act;
    logic [9:0]  a, b, c;
    logic [15:0] x, y, z;
  } mesh_op_t;

  typedef struct {
    logic [9:0]  idx;
    logic [15:0] nx, ny, nz;
    logic        deg;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vna_in_if  in_if ();
  vna_out_if out_if ();

  vertex_normal_accumulator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // mesh state as the block should hold it
  logic signed [15:0] mesh_pos [1024][3];
  longint             mesh_sum [1024][3];

  mesh_op_t pending_ops [$];
  normal_t  normals_due [$];
  logic [9:0] written_idx [$];
  bit         written_map [1024];

  int  cycles, errors, n_writes, n_tris, n_reads, n_checked, n_sat, n_degen;
  bit  in_taken, calm, hold_done;
  int  send_gap, recv_gap, calm_cnt;

  function automatic longint sat_sum(longint s, longint d);
    longint r;
    r = s + d;
    if (r > SUM_HI) return SUM_HI;
    if (r < SUM_LO) return SUM_LO;
    return r;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic normal_t unit_normal(logic [9:0] idx, longint sx, longint sy, longint sz);
    longint      s [3];
    logic [63:0] mag [3];
    logic [63:0] m, sq, len, q;
    logic [15:0] comp [3];
    normal_t     r;
    s[0] = sx; s[1] = sy; s[2] = sz;
    r.idx = idx;
    for (int i = 0; i < 3; i++) mag[i] = s[i] < 0 ? 64'(-s[i]) : 64'(s[i]);
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    if (m == 0) begin
      r.nx = 0; r.ny = 0; r.nz = vna_pkg::ONE_Q14; r.deg = 1'b1;
      return r;
    end
    while (m >= (64'd1 << 20)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 19)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd32768 + len) / (64'd2 * len);
      if (s[i] < 0) q = -q;
      comp[i] = q[15:0];
    end
    r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.deg = 1'b0;
    return r;
  endfunction

  task automatic apply_op(mesh_op_t op);
    longint e1 [3];
    longint e2 [3];
    longint cr [3];
    longint nv;
    logic [9:0] corner [3];
    case (op.act)
      vna_pkg::ACT_WRITE: begin
        mesh_pos[op.a][0] = op.x;
        mesh_pos[op.a][1] = op.y;
        mesh_pos[op.a][2] = op.z;
        for (int i = 0; i < 3; i++) mesh_sum[op.a][i] = 0;
        n_writes++;
      end
      vna_pkg::ACT_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(mesh_pos[op.b][i]) - longint'(mesh_pos[op.a][i]);
          e2[i] = longint'(mesh_pos[op.c][i]) - longint'(mesh_pos[op.a][i]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        corner[0] = op.a; corner[1] = op.b; corner[2] = op.c;
        // corners in order, so a repeated corner is added twice
        for (int k = 0; k < 3; k++) begin
          for (int i = 0; i < 3; i++) begin
            nv = sat_sum(mesh_sum[corner[k]][i], cr[i]);
            if (nv != mesh_sum[corner[k]][i] + cr[i]) n_sat++;
            mesh_sum[corner[k]][i] = nv;
          end
        end
        n_tris++;
      end
      vna_pkg::ACT_READ: begin
        normals_due.push_back(unit_normal(op.a, mesh_sum[op.a][0], mesh_sum[op.a][1],
                                          mesh_sum[op.a][2]));
        n_reads++;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    normal_t want;
    in_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      mesh_op_t op;
      op.act = vna_pkg::action_e'(in_if.action);
      op.a = in_if.index_a; op.b = in_if.index_b; op.c = in_if.index_c;
      op.x = in_if.pos_x; op.y = in_if.pos_y; op.z = in_if.pos_z;
      apply_op(op);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected normal for vertex %0d", $time, out_if.vertex_index);
        errors++;
      end else begin
        want = normals_due.pop_front();
        check_field("vertex_index", want.idx, out_if.vertex_index);
        check_field("normal_x", $signed(want.nx), $signed(out_if.normal_x));
        check_field("normal_y", $signed(want.ny), $signed(out_if.normal_y));
        check_field("normal_z", $signed(want.nz), $signed(out_if.normal_z));
        check_field("degenerate", want.deg, out_if.degenerate);
        if (want.deg) n_degen++;
        n_checked++;
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // sender, changes at the falling edge
  always @(negedge clk_i) begin
    mesh_op_t op;
    calm_cnt <= (calm_cnt == 0) ? $urandom_range(100, 400) : calm_cnt - 1;
    if (calm_cnt == 0) calm <= ($urandom_range(0, 3) == 0);
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_if.valid   <= 1'b1;
        in_if.action  <= op.act;
        in_if.index_a <= op.a;
        in_if.index_b <= op.b;
        in_if.index_c <= op.c;
        in_if.pos_x   <= op.x;
        in_if.pos_y   <= op.y;
        in_if.pos_z   <= op.z;
        send_gap <= next_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while a normal waits
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!hold_done && out_if.valid && normals_due.size() != 0) begin
        hold_done <= 1'b1;
        recv_gap <= 600;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= next_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d normals outstanding", cycles,
               normals_due.size());
      $display("vertex_normal_accumulator verification failed");
      $finish;
    end
  end

  task automatic queue_op(vna_pkg::action_e act, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                          logic [15:0] x, logic [15:0] y, logic [15:0] z);
    mesh_op_t op;
    op.act = act; op.a = a; op.b = b; op.c = c; op.x = x; op.y = y; op.z = z;
    if (act == vna_pkg::ACT_WRITE && !written_map[a]) begin
      written_map[a] = 1'b1;
      written_idx.push_back(a);
    end
    pending_ops.push_back(op);
  endtask

  function automatic logic [9:0] any_written();
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 5) return 16'($signed($urandom_range(0, 511)) - 256);
    return 16'($urandom);
  endfunction

  initial begin
    int r;
    logic [9:0] a;
    in_if.valid = 1'b0;
    in_if.action = vna_pkg::ACT_NONE;
    in_if.index_a = '0; in_if.index_b = '0; in_if.index_c = '0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
    out_if.ready = 1'b0;
    calm = 1'b0; calm_cnt = 0; send_gap = 0; recv_gap = 0; hold_done = 1'b0;

    // directed: extreme positions, zero sums, repeated corner, ignored action
    queue_op(vna_pkg::ACT_WRITE, 0, 0, 0, 16'h8000, 16'h8000, 16'h0000);
    queue_op(vna_pkg::ACT_WRITE, 1, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
    queue_op(vna_pkg::ACT_WRITE, 2, 0, 0, 16'h8000, 16'h7fff, 16'h0000);
    queue_op(vna_pkg::ACT_WRITE, 3, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_op(vna_pkg::ACT_WRITE, 1023, 0, 0, 16'h0000, 16'h0000, 16'h8000);
    queue_op(vna_pkg::ACT_WRITE, 512, 0, 0, 16'hffff, 16'hffff, 16'hffff);
    queue_op(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_TRI, 0, 1, 2, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 1, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 2, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_TRI, 0, 0, 1, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_TRI, 3, 1023, 512, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 1023, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 3, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_TRI, 1, 2, 3, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 3, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_NONE, 10'h3ff, 10'h2aa, 10'h155, 16'hffff, 16'h5555, 16'haaaa);
    queue_op(vna_pkg::ACT_WRITE, 0, 0, 0, 16'h1234, 16'hfedc, 16'h0001);
    queue_op(vna_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 512, 0, 0, 0, 0, 0);

    // one triangle repeated until its corner sums hit the positive limit
    queue_op(vna_pkg::ACT_WRITE, 100, 0, 0, 16'h8000, 16'h8000, 16'h0000);
    queue_op(vna_pkg::ACT_WRITE, 101, 0, 0, 16'h7fff, 16'h8000, 16'h0000);
    queue_op(vna_pkg::ACT_WRITE, 102, 0, 0, 16'h8000, 16'h7fff, 16'h0000);
    for (int i = 0; i < SAT_TRIS; i++) begin
      queue_op(vna_pkg::ACT_TRI, 100, 101, 102, 0, 0, 0);
      if (i % 256 == 255) queue_op(vna_pkg::ACT_READ, 10'(100 + i % 3), 0, 0, 0, 0, 0);
    end
    queue_op(vna_pkg::ACT_TRI, 100, 102, 101, 0, 0, 0);
    queue_op(vna_pkg::ACT_READ, 100, 0, 0, 0, 0, 0);

    // random mesh traffic, triangles and reads over written vertices only
    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20 || written_idx.size() < 4) begin
        queue_op(vna_pkg::ACT_WRITE, 10'($urandom), 0, 0, rand_coord(), rand_coord(),
                 rand_coord());
      end else if (r < 65) begin
        a = any_written();
        queue_op(vna_pkg::ACT_TRI, a, ($urandom_range(0, 9) == 0) ? a : any_written(),
                 any_written(), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 95) begin
        queue_op(vna_pkg::ACT_READ, any_written(), 10'($urandom), 10'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        queue_op(vna_pkg::ACT_NONE, 10'($urandom), 10'($urandom), 10'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_ops.size() == 0 && !in_if.valid && normals_due.size() == 0);
    repeat (200) @(posedge clk_i);

    $display("%0d vertex writes, %0d triangles and %0d normal reads accepted",
             n_writes, n_tris, n_reads);
    $display("%0d normals checked (%0d degenerate), %0d saturating sum updates",
             n_checked, n_degen, n_sat);
    if (errors == 0 && normals_due.size() == 0) begin
      $display("vertex_normal_accumulator verification clean");
    end else begin
      $display("vertex_normal_accumulator verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vna_pkg.sv
rtl/vna_if.sv
rtl/vna_ram.sv
rtl/vertex_normal_accumulator.sv
test/vertex_normal_accumulator_tb.sv
